// ===== hdl/bll_pkg.sv =====
package bll_pkg;

    // default store size
    localparam int NODE_CAPACITY_DEF = 64;

    // field widths fixed by the item format
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int POS_W = 6;
    localparam int ST_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE     = 2'd2;
    localparam logic [OP_W-1:0] OP_READ       = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

    // write enables from the sequencer to the node store
    typedef struct packed {
        logic val_we;
        logic link_we;
    } bll_mem_we_t;

endpackage

// ===== hdl/bounded_linked_list_engine.sv =====
// channel  | signals                        | transfer
// ---------+--------------------------------+------------------------------------
// command  | start, busy, op, value,        | rising edge with start high and
//          | position                       | busy low
// result   | done, status, length,          | every cycle with done high, one
//          | read_value                     | cycle wide, always taken
//
// push front, or push back onto an empty list, runs S_PUSH; push back onto a
// non-empty list adds S_LINK to link the old tail. remove walks in S_SEARCH,
// plus S_UNLINK if the match is not the head; read walks in S_READ, one node
// per cycle through the node store read port. a full push, a remove on an
// empty list and an out-of-range read answer from idle. after reset S_INIT
// builds the free list with busy high; the result side has no back pressure.
module bounded_linked_list_engine
    import bll_pkg::*;
#(
    parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [OP_W-1:0]                      op,
    input  logic signed [VAL_W-1:0]              value,
    input  logic [POS_W-1:0]                     position,
    output logic                                 done,
    output logic [ST_W-1:0]                      status,
    output logic [$clog2(NODE_CAPACITY+1)-1:0]   length,
    output logic signed [VAL_W-1:0]              read_value
);

    localparam int IDX_W = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
    localparam int CNT_W = $clog2(NODE_CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODE_CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NODE_CAPACITY);

    // sequencer states
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PUSH   = 3'd2;
    localparam logic [2:0] S_LINK   = 3'd3;
    localparam logic [2:0] S_SEARCH = 3'd4;
    localparam logic [2:0] S_UNLINK = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0] nxt_reg, nxt_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic [ST_W-1:0]  status_reg, status_next;
    logic [CNT_W-1:0] length_reg, length_next;
    logic [VAL_W-1:0] rdval_reg, rdval_next;

    bll_mem_we_t      mem_we;
    logic [IDX_W-1:0] val_waddr;
    logic [IDX_W-1:0] link_waddr;
    logic [IDX_W-1:0] link_wdata;
    logic [VAL_W-1:0] val_rd;
    logic [IDX_W-1:0] link_rd;

    logic             hit;
    logic             at_pos;
    logic             last_node;

    // node store, read address follows cur so read data always matches cur_reg
    bll_node_mem #(
        .NODE_CAPACITY (NODE_CAPACITY)
    ) u_mem (
        .clk        (clk),
        .we         (mem_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_reg),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .raddr      (cur_next),
        .val_rdata  (val_rd),
        .link_rdata (link_rd)
    );

    // per-step compares
    assign hit       = (val_rd == val_reg);
    assign at_pos    = (CMP_W'(k_reg) == CMP_W'(pos_reg));
    assign last_node = ((k_reg + CNT_W'(1)) == count_reg);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        length_next = length_reg;
        rdval_next  = rdval_reg;
        mem_we      = '0;
        val_waddr   = cur_reg;
        link_waddr  = cur_reg;
        link_wdata  = '0;

        case (state_reg)
            S_INIT:
            begin
                // chain every node into the free list
                mem_we.link_we = 1'b1;
                if (cur_reg == LAST_IDX)
                begin
                    link_wdata = '0;
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    link_wdata = cur_reg + IDX_W'(1);
                    cur_next   = cur_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = op;
                    val_next  = value;
                    pos_next  = position;
                    k_next    = '0;
                    prev_next = '0;
                    case (op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                                length_next = count_reg;
                                rdval_next  = '0;
                            end
                            else
                            begin
                                cur_next   = free_reg;
                                state_next = S_PUSH;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                                length_next = count_reg;
                                rdval_next  = '0;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_READ:
                        begin
                            if (CMP_W'(position) >= CMP_W'(count_reg))
                            begin
                                done_next   = 1'b1;
                                status_next = ST_RANGE;
                                length_next = count_reg;
                                rdval_next  = '0;
                            end
                            else
                            begin
                                cur_next   = head_reg;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                // take the free node, store value and its link
                mem_we.val_we  = 1'b1;
                mem_we.link_we = 1'b1;
                free_next      = link_rd;
                count_next     = count_reg + CNT_W'(1);
                if (op_reg == OP_PUSH_FRONT)
                begin
                    link_wdata = head_reg;
                    head_next  = cur_reg;
                    if (count_reg == '0)
                    begin
                        tail_next = cur_reg;
                    end
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    length_next = count_reg + CNT_W'(1);
                    rdval_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    link_wdata = '0;
                    tail_next  = cur_reg;
                    prev_next  = tail_reg;
                    if (count_reg == '0)
                    begin
                        head_next   = cur_reg;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        length_next = count_reg + CNT_W'(1);
                        rdval_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LINK;
                    end
                end
            end

            S_LINK:
            begin
                // old tail points at the new node
                mem_we.link_we = 1'b1;
                link_waddr     = prev_reg;
                link_wdata     = cur_reg;
                done_next      = 1'b1;
                status_next    = ST_OK;
                length_next    = count_reg;
                rdval_next     = '0;
                state_next     = S_IDLE;
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    // return the node to the free list
                    nxt_next       = link_rd;
                    mem_we.link_we = 1'b1;
                    link_wdata     = free_reg;
                    free_next      = cur_reg;
                    count_next     = count_reg - CNT_W'(1);
                    if (k_reg == '0)
                    begin
                        head_next = link_rd;
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                            tail_next = '0;
                        end
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        length_next = count_reg - CNT_W'(1);
                        rdval_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        if (last_node)
                        begin
                            tail_next = prev_reg;
                        end
                        state_next = S_UNLINK;
                    end
                end
                else if (last_node)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    length_next = count_reg;
                    rdval_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    k_next    = k_reg + CNT_W'(1);
                end
            end

            S_UNLINK:
            begin
                // predecessor skips the removed node
                mem_we.link_we = 1'b1;
                link_waddr     = prev_reg;
                link_wdata     = nxt_reg;
                done_next      = 1'b1;
                status_next    = ST_OK;
                length_next    = count_reg;
                rdval_next     = '0;
                state_next     = S_IDLE;
            end

            S_READ:
            begin
                if (at_pos)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    length_next = count_reg;
                    rdval_next  = val_rd;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cur_next = link_rd;
                    k_next   = k_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            head_reg  <= '0;
            tail_reg  <= '0;
            free_reg  <= '0;
            cur_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // operands, walk registers and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        pos_reg    <= pos_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        k_reg      <= k_next;
        status_reg <= status_next;
        length_reg <= length_next;
        rdval_reg  <= rdval_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign length     = length_reg;
    assign read_value = rdval_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("node count above capacity");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (length == FULL_CNT))
        else $error("full status with list not full");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg == '0) |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with stale head or tail");

    a_rdval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (read_value == '0))
        else $error("read value on failed operation");

    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
            && count_reg != FULL_CNT) |=> (busy && !done))
        else $error("push not started");

endmodule

// ===== hdl/bll_node_mem.sv =====
module bll_node_mem
    import bll_pkg::*;
#(
    parameter int NODE_CAPACITY = NODE_CAPACITY_DEF
)
(
    input  logic                                              clk,
    input  bll_mem_we_t                                       we,
    input  logic [((NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1)-1:0] val_waddr,
    input  logic [VAL_W-1:0]                                  val_wdata,
    input  logic [((NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1)-1:0] link_waddr,
    input  logic [((NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1)-1:0] link_wdata,
    input  logic [((NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1)-1:0] raddr,
    output logic [VAL_W-1:0]                                  val_rdata,
    output logic [((NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1)-1:0] link_rdata
);

    localparam int IDX_W = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;

    logic [VAL_W-1:0] val_mem  [NODE_CAPACITY];
    logic [IDX_W-1:0] link_mem [NODE_CAPACITY];

    // node values, read data registered
    always_ff @(posedge clk)
    begin
        if (we.val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata <= val_mem[raddr];
    end

    // next links, read data registered
    always_ff @(posedge clk)
    begin
        if (we.link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata <= link_mem[raddr];
    end

endmodule
